@@ rtl/core/ipmc_pkg.sv @@
// Package for the inactivity power mode controller.
// Holds the level, opcode, register index and power source codes and the shared types.
// No dependencies.
package ipmc_pkg;

  // Threshold register width, fixed by the register map
  localparam int unsigned THR_W     = 24;
  localparam int unsigned LVL_W     = 3;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned PSRC_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = THR_W;

  // Power levels
  localparam logic [LVL_W-1:0] LVL_ACTIVE = 3'd0;
  localparam logic [LVL_W-1:0] LVL_NORMAL = 3'd1;
  localparam logic [LVL_W-1:0] LVL_IDLE   = 3'd2;
  localparam logic [LVL_W-1:0] LVL_SLEEP  = 3'd3;
  localparam logic [LVL_W-1:0] LVL_DEEP   = 3'd4;

  // Input opcodes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_ACT   = 2'd1;
  localparam logic [OP_W-1:0] OP_POWER = 2'd2;
  localparam logic [OP_W-1:0] OP_WAKE  = 2'd3;

  // Power source codes
  localparam logic [PSRC_W-1:0] PSRC_BATTERY = 2'd0;
  localparam logic [PSRC_W-1:0] PSRC_USB     = 2'd1;
  localparam logic [PSRC_W-1:0] PSRC_CHARGE  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_AFTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_AFTER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_AFTER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEEP_AFTER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_ON       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_LEVEL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_SLEEP_OFF = 3'd6;

  // Register reset values
  localparam logic [THR_W-1:0] NORMAL_AFTER_RST = 24'd5000;
  localparam logic [THR_W-1:0] IDLE_AFTER_RST   = 24'd30000;
  localparam logic [THR_W-1:0] SLEEP_AFTER_RST  = 24'd300000;
  localparam logic [THR_W-1:0] DEEP_AFTER_RST   = 24'd1800000;

  typedef struct packed {
    logic [THR_W-1:0] normal_after;
    logic [THR_W-1:0] idle_after;
    logic [THR_W-1:0] sleep_after;
    logic [THR_W-1:0] deep_after;
    logic             force_on;
    logic [LVL_W-1:0] force_level;
    logic             auto_sleep_off;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            usb_present;
    logic            charge_now;
    logic            radio_ble_mode;
    logic            radio_linked;
  } in_item_t;

endpackage

@@ rtl/core/ipmc_ifs.sv @@
// Channel interfaces for the inactivity power mode controller.
// Input word channel and result word channel; no dependencies.
interface ipmc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       usb_present;
  logic       charge_now;
  logic       radio_ble_mode;
  logic       radio_linked;

  modport source (output valid, op, usb_present, charge_now, radio_ble_mode, radio_linked,
                  input ready);
  modport sink   (input valid, op, usb_present, charge_now, radio_ble_mode, radio_linked,
                  output ready);
endinterface

interface ipmc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       mode_changed;
  logic [1:0] power_source;

  modport source (output valid, mode, mode_changed, power_source, input ready);
  modport sink   (input valid, mode, mode_changed, power_source, output ready);
endinterface

@@ rtl/core/ipmc_cfg_regs.sv @@
// Configuration register file: thresholds, force control and auto-sleep switch.
// Depends on ipmc_pkg.
module ipmc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ipmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ipmc_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  output ipmc_pkg::cfg_t                    cfg
);
  import ipmc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; unknown indexes leave everything alone
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_AFTER:   cfg_nxt.normal_after   = cfg_wdata[THR_W-1:0];
        REG_IDLE_AFTER:     cfg_nxt.idle_after     = cfg_wdata[THR_W-1:0];
        REG_SLEEP_AFTER:    cfg_nxt.sleep_after    = cfg_wdata[THR_W-1:0];
        REG_DEEP_AFTER:     cfg_nxt.deep_after     = cfg_wdata[THR_W-1:0];
        REG_FORCE_ON:       cfg_nxt.force_on       = cfg_wdata[0];
        REG_FORCE_LEVEL:    cfg_nxt.force_level    = cfg_wdata[LVL_W-1:0];
        REG_AUTO_SLEEP_OFF: cfg_nxt.auto_sleep_off = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_after   <= NORMAL_AFTER_RST;
      cfg_r.idle_after     <= IDLE_AFTER_RST;
      cfg_r.sleep_after    <= SLEEP_AFTER_RST;
      cfg_r.deep_after     <= DEEP_AFTER_RST;
      cfg_r.force_on       <= 1'b0;
      cfg_r.force_level    <= LVL_ACTIVE;
      cfg_r.auto_sleep_off <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/ipmc_in_reg.sv @@
// Input register: captures one input word and holds it until the step unit takes it.
// Depends on ipmc_pkg and ipmc_in_if.
module ipmc_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  ipmc_in_if.sink              in_ch,
  output ipmc_pkg::in_item_t   item,
  output logic                 item_vld,
  input  logic                 item_take
);
  import ipmc_pkg::*;

  logic     vld_r;
  in_item_t item_r;
  logic     load;

  // Accept a new word when empty or when the held word leaves this cycle
  assign in_ch.ready = !vld_r || item_take;
  assign load        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.op             <= in_ch.op;
      item_r.usb_present    <= in_ch.usb_present;
      item_r.charge_now     <= in_ch.charge_now;
      item_r.radio_ble_mode <= in_ch.radio_ble_mode;
      item_r.radio_linked   <= in_ch.radio_linked;
    end
  end

  assign item     = item_r;
  assign item_vld = vld_r;

endmodule

@@ rtl/core/ipmc_step.sv @@
// Step unit: mode state, inactivity counter, power flags and the result register.
// Depends on ipmc_pkg and ipmc_out_if.
module ipmc_step #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ipmc_pkg::cfg_t       cfg,
  input  ipmc_pkg::in_item_t   item,
  input  logic                 item_vld,
  output logic                 item_take,
  ipmc_out_if.source           out_ch
);
  import ipmc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [LVL_W-1:0]      lvl_r,   lvl_nxt;
  logic [COUNT_BITS-1:0] ticks_r, ticks_nxt;
  logic                  usb_r,   usb_nxt;
  logic                  chg_r,   chg_nxt;

  logic                  out_vld_r;
  logic [LVL_W-1:0]      out_mode_r;
  logic                  out_changed_r;
  logic [PSRC_W-1:0]     out_psrc_r;
  logic [PSRC_W-1:0]     psrc_nxt;

  logic                  take;
  logic                  fire;
  logic [COUNT_BITS-1:0] ticks_inc;
  logic [CMP_W-1:0]      ticks_ext;
  logic [LVL_W-1:0]      target;
  logic                  sleep_block;
  logic                  deep_block;

  // Result register frees up when empty or being drained
  assign take      = !out_vld_r || out_ch.ready;
  assign item_take = take;
  assign fire      = item_vld && take;

  // Saturating tick count
  assign ticks_inc = (ticks_r == CNT_MAX) ? ticks_r : ticks_r + COUNT_BITS'(1);
  assign ticks_ext = CMP_W'(ticks_inc);

  // Inactivity target; BLE radio mode blocks deep, a BLE link also blocks sleep
  assign sleep_block = item.radio_ble_mode && item.radio_linked;
  assign deep_block  = item.radio_ble_mode;

  always_comb begin
    if (ticks_ext >= CMP_W'(cfg.deep_after)) begin
      target = LVL_DEEP;
    end else if (ticks_ext >= CMP_W'(cfg.sleep_after)) begin
      target = LVL_SLEEP;
    end else if (ticks_ext >= CMP_W'(cfg.idle_after)) begin
      target = LVL_IDLE;
    end else if (ticks_ext >= CMP_W'(cfg.normal_after)) begin
      target = LVL_NORMAL;
    end else begin
      target = LVL_ACTIVE;
    end
    if (target == LVL_DEEP && deep_block) begin
      target = LVL_SLEEP;
    end
    if (target == LVL_SLEEP && sleep_block) begin
      target = LVL_IDLE;
    end
  end

  // Next state for the word in the input register
  always_comb begin
    lvl_nxt   = lvl_r;
    ticks_nxt = ticks_r;
    usb_nxt   = usb_r;
    chg_nxt   = chg_r;
    case (item.op)
      OP_TICK: begin
        ticks_nxt = ticks_inc;
        if (cfg.force_on) begin
          lvl_nxt = (cfg.force_level > LVL_DEEP) ? LVL_DEEP : cfg.force_level;
        end else if (usb_r || chg_r) begin
          if (lvl_r > LVL_NORMAL) begin
            lvl_nxt = LVL_ACTIVE;
          end
        end else if (!cfg.auto_sleep_off) begin
          lvl_nxt = target;
        end
      end
      OP_POWER: begin
        usb_nxt = item.usb_present;
        chg_nxt = item.charge_now;
        // Start of charging wakes a low power mode
        if (item.charge_now && !chg_r && lvl_r != LVL_ACTIVE) begin
          ticks_nxt = '0;
          lvl_nxt   = LVL_ACTIVE;
        end
      end
      OP_ACT, OP_WAKE: begin
        ticks_nxt = '0;
        lvl_nxt   = LVL_ACTIVE;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (chg_nxt) begin
      psrc_nxt = PSRC_CHARGE;
    end else if (usb_nxt) begin
      psrc_nxt = PSRC_USB;
    end else begin
      psrc_nxt = PSRC_BATTERY;
    end
  end

  // Advance state on each consumed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r   <= LVL_ACTIVE;
      ticks_r <= '0;
      usb_r   <= 1'b0;
      chg_r   <= 1'b0;
    end else if (fire) begin
      lvl_r   <= lvl_nxt;
      ticks_r <= ticks_nxt;
      usb_r   <= usb_nxt;
      chg_r   <= chg_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take) begin
      out_vld_r <= item_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_mode_r    <= lvl_nxt;
      out_changed_r <= (lvl_nxt != lvl_r);
      out_psrc_r    <= psrc_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.mode         = out_mode_r;
  assign out_ch.mode_changed = out_changed_r;
  assign out_ch.power_source = out_psrc_r;

  // Activity and wake always land in active with a cleared count
  a_wake_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.op == OP_ACT || item.op == OP_WAKE)
      |=> ticks_r == '0 && lvl_r == LVL_ACTIVE)
    else $error("activity or wake did not return to active");

  // Reported change flag matches the state register
  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_ch.mode_changed == (lvl_r != $past(lvl_r)) && out_ch.mode == lvl_r)
    else $error("result word disagrees with mode state");

  // Count only grows or clears
  a_ticks_mono: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> ticks_r == '0 || ticks_r >= $past(ticks_r))
    else $error("inactivity count went backwards");

  // State holds while no word is consumed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(lvl_r) && $stable(ticks_r) && $stable(chg_r))
    else $error("state changed without a word");

endmodule

@@ rtl/core/inactivity_power_mode_controller_top.sv @@
// Top level of the inactivity power mode controller.
// Uses ipmc_pkg, ipmc_in_if, ipmc_out_if, ipmc_cfg_regs, ipmc_in_reg and ipmc_step.
//
// Usage:
//   in_ch  carries one word per event: a 1 ms tick, user activity, a power
//          status update or a wake, with the radio status for the tick rules.
//   out_ch returns exactly one word per input word: the mode after it, a
//          flag that the word changed the mode, and the power source.
//   cfg_we/cfg_index/cfg_wdata write the thresholds and mode controls; write
//          only while no word is in flight.
// Each word passes the input register, then the result register.
// Throughput is one word per cycle while out_ch does not stall; the mode,
// count and flag update is a single compare-and-select pass from the input register.
// When out_ch stalls, the result and the word behind it are held; in_ch
// stays ready while the input register is empty.
// Reset (rst_n low, synchronous) returns to active, clears the count and
// the power flags, loads the register defaults and empties both stages.
module inactivity_power_mode_controller_top #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ipmc_in_if.sink                         in_ch,
  ipmc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ipmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipmc_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import ipmc_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  logic      item_vld;
  logic      item_take;

  ipmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ipmc_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .item      (item),
    .item_vld  (item_vld),
    .item_take (item_take)
  );

  ipmc_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item      (item),
    .item_vld  (item_vld),
    .item_take (item_take),
    .out_ch    (out_ch)
  );

endmodule
